/* hdl/grlt_pkg.sv */
// ----------------------------------------------------------------------------
// grlt_pkg: shared types and constants for the repeat limit table
// Holds the token that walks the cell chain and the default table size.
// ----------------------------------------------------------------------------
package grlt_pkg;

    localparam int TableDepthDefault  = 256;
    localparam int KeyW               = 32;
    localparam int CountW             = 8;
    localparam logic [CountW-1:0] DefaultLimitReset = 8'd3;

    // token passed from cell to cell, one beat per cycle
    typedef struct packed {
        logic              vld;    // token present in this stage
        logic              done;   // an earlier cell has dealt with the key
        logic              stop;   // key was at its limit
        logic              ins;    // key was inserted as a new entry
        logic [KeyW-1:0]   key;
        logic [CountW-1:0] limit;  // resolved limit, never zero-means-default
        logic [CountW-1:0] count;  // count held for the key after the step
    } t_tok;

endpackage

/* hdl/grlt_cell.sv */
// ----------------------------------------------------------------------------
// grlt_cell: one entry of the repeat limit table
// Holds one key and its count, matches or inserts the passing token and
// hands the token on to the next cell in the cycle after.
// ----------------------------------------------------------------------------
module grlt_cell #(
    parameter int IDX_W    = 8,
    parameter int CELL_IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_occupancy,
    input  grlt_pkg::t_tok   i_tok,
    output grlt_pkg::t_tok   o_tok
);

    localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

    logic [grlt_pkg::KeyW-1:0]   r_key;
    logic [grlt_pkg::CountW-1:0] r_count;
    grlt_pkg::t_tok              r_tok;
    grlt_pkg::t_tok              n_tok;

    logic w_active;
    logic w_hit;
    logic w_ins;
    logic w_at_limit;

    // entry is live when it lies below the fill count
    assign w_active   = i_tok.vld && !i_tok.done;
    assign w_hit      = w_active && (MyIdx < i_occupancy) && (r_key == i_tok.key);
    assign w_ins      = w_active && (MyIdx == i_occupancy);
    assign w_at_limit = (r_count >= i_tok.limit);

    // outgoing token
    always_comb begin
        n_tok = i_tok;
        if (w_hit) begin
            n_tok.done = 1'b1;
            if (w_at_limit) begin
                n_tok.stop  = 1'b1;
                n_tok.count = r_count;
            end else begin
                n_tok.count = r_count + 1'b1;
            end
        end else if (w_ins) begin
            n_tok.done  = 1'b1;
            n_tok.ins   = 1'b1;
            n_tok.count = grlt_pkg::CountW'(1);
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_hit && !w_at_limit) begin
            r_count <= r_count + 1'b1;
        end else if (w_ins) begin
            r_key   <= i_tok.key;
            r_count <= grlt_pkg::CountW'(1);
        end
    end

    // token stage: only the valid bit needs a reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= n_tok.vld;
        end
        r_tok.done  <= n_tok.done;
        r_tok.stop  <= n_tok.stop;
        r_tok.ins   <= n_tok.ins;
        r_tok.key   <= n_tok.key;
        r_tok.limit <= n_tok.limit;
        r_tok.count <= n_tok.count;
    end

    assign o_tok = r_tok;

endmodule

/* hdl/gossip_repeat_limit_table.sv */
// ----------------------------------------------------------------------------
// gossip_repeat_limit_table: counting duplicate message filter
// A chain of entry cells; each message key walks the chain, is counted
// against its repeat limit or inserted, and the table empties once full.
//
//   channel   | handshake            | payload
//   ----------+----------------------+---------------------------------------
//   item in   | start, busy          | i_msg_key, i_repeat_limit
//   result    | o_done (strobe)      | o_stop, o_seen_count, o_table_cleared
//   config    | i_cfg_we             | i_cfg_data (default_limit)
//
// The result beat shows after the accepting edge, once the token has passed
// through every cell of the chain, one cell per cycle, and the tail is
// registered onto the result ports. busy stays high until the result shows,
// so a new item is taken at the edge that ends the result beat; no new item
// is taken while one is in the chain. The fill count marks the live entries,
// so reset and a full-table clear only zero the fill count.
// The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module gossip_repeat_limit_table #(
    parameter int TABLE_DEPTH = grlt_pkg::TableDepthDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [grlt_pkg::KeyW-1:0]     i_msg_key,
    input  logic [grlt_pkg::CountW-1:0]   i_repeat_limit,
    input  logic                          i_cfg_we,
    input  logic [grlt_pkg::CountW-1:0]   i_cfg_data,
    output logic                          o_done,
    output logic                          o_stop,
    output logic [grlt_pkg::CountW-1:0]   o_seen_count,
    output logic                          o_table_cleared
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LastIdx = IDX_W'(TABLE_DEPTH - 1);

    logic                        r_busy;
    logic [IDX_W-1:0]            r_occupancy;
    logic [grlt_pkg::CountW-1:0] r_default_limit;
    logic                        r_done;
    logic                        r_stop;
    logic [grlt_pkg::CountW-1:0] r_seen_count;
    logic                        r_table_cleared;

    logic                        w_accept;
    logic                        w_full;
    grlt_pkg::t_tok              w_head;
    grlt_pkg::t_tok              w_tail;
    grlt_pkg::t_tok              w_tok [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]      w_tok_vld;

    assign busy     = r_busy || !i_rst_n;
    assign w_accept = start && !busy;

    // head token, limit of zero picks the configured default
    always_comb begin
        w_head.vld   = w_accept;
        w_head.done  = 1'b0;
        w_head.stop  = 1'b0;
        w_head.ins   = 1'b0;
        w_head.key   = i_msg_key;
        w_head.limit = (i_repeat_limit == '0) ? r_default_limit : i_repeat_limit;
        w_head.count = '0;
    end

    // chain of entry cells
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            grlt_cell #(
                .IDX_W    (IDX_W),
                .CELL_IDX (g)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_occupancy (r_occupancy),
                .i_tok       (w_head),
                .o_tok       (w_tok[g])
            );
        end else begin : g_rest
            grlt_cell #(
                .IDX_W    (IDX_W),
                .CELL_IDX (g)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_occupancy (r_occupancy),
                .i_tok       (w_tok[g-1]),
                .o_tok       (w_tok[g])
            );
        end
        assign w_tok_vld[g] = w_tok[g].vld;
    end

    assign w_tail = w_tok[TABLE_DEPTH-1];
    // an insert into the last slot fills the table
    assign w_full = w_tail.ins && (r_occupancy == LastIdx);

    // control: busy flag, fill count, default limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy          <= 1'b0;
            r_occupancy     <= '0;
            r_default_limit <= grlt_pkg::DefaultLimitReset;
            r_done          <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_default_limit <= i_cfg_data;
            end
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_tail.vld) begin
                r_busy <= 1'b0;
            end
            if (w_tail.vld && w_tail.ins) begin
                r_occupancy <= w_full ? '0 : r_occupancy + 1'b1;
            end
            r_done <= w_tail.vld;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_tail.vld) begin
            r_stop          <= w_tail.stop;
            r_seen_count    <= w_full ? '0 : w_tail.count;
            r_table_cleared <= w_full;
        end
    end

    assign o_done          = r_done;
    assign o_stop          = r_stop;
    assign o_seen_count    = r_seen_count;
    assign o_table_cleared = r_table_cleared;

`ifndef NO_ASSERTIONS
    // only one item is ever in the chain
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_vld))
        else $error("more than one token in the cell chain");

    // a result only ends a busy period
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy))
        else $error("result strobe without an item in flight");

    // a cleared table reports no count and no stop
    a_clear_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_table_cleared) |-> (!o_stop && o_seen_count == '0
            && r_occupancy == '0))
        else $error("inconsistent table clear result");

    // a stop answer leaves the fill count alone
    a_stop_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tail.vld && w_tail.stop) |=> $stable(r_occupancy))
        else $error("fill count changed on a stop answer");
`endif

endmodule
